// ===== design/assert_macros.svh =====
// Assertion helpers used by the clipper top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk and arst_n of a module.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

// ===== design/lsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrc_pkg
// Outcode bits, register indexes and the outcode function of the clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;

	// Widest coordinate the outcode function handles.
	localparam int MAX_COORD_BITS = 32;

	// Reset value of the right and top edges before truncation to the width.
	localparam int CLIP_MAX_RESET = 32767;

	// Bit positions inside an outcode.
	localparam int OC_LEFT   = 0;
	localparam int OC_RIGHT  = 1;
	localparam int OC_BOTTOM = 2;
	localparam int OC_TOP    = 3;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_X_MIN = 2'd0,
		REG_X_MAX = 2'd1,
		REG_Y_MIN = 2'd2,
		REG_Y_MAX = 2'd3
	} clip_reg_t;

	typedef logic [3:0] outcode_t;

	// Region code of a point against the rectangle; callers sign-extend.
	function automatic outcode_t outcode(
		input logic signed [MAX_COORD_BITS-1:0] x,
		input logic signed [MAX_COORD_BITS-1:0] y,
		input logic signed [MAX_COORD_BITS-1:0] x_min,
		input logic signed [MAX_COORD_BITS-1:0] x_max,
		input logic signed [MAX_COORD_BITS-1:0] y_min,
		input logic signed [MAX_COORD_BITS-1:0] y_max
	);
		outcode_t c;
		c = '0;
		if (x < x_min) begin
			c[OC_LEFT] = 1'b1;
		end else if (x > x_max) begin
			c[OC_RIGHT] = 1'b1;
		end
		if (y < y_min) begin
			c[OC_BOTTOM] = 1'b1;
		end else if (y > y_max) begin
			c[OC_TOP] = 1'b1;
		end
		return c;
	endfunction

endpackage

// ===== design/line_segment_rect_clip_top.sv =====
// A segment clipper that takes one segment per clock while the output is not
// stalled and returns one result per segment, in order, through the chain of
// clip passes, each one holding a multiplier and a divider that retires one
// quotient bit per stage. The whole pipeline advances together and holds while
// a result waits to be taken.
// Write the clip rectangle only while no segment is in flight.
// ----------------------------------------------------------------------------
// line_segment_rect_clip_top
// Cohen-Sutherland clipping of segments against a configured rectangle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_segment_rect_clip_top #(
	parameter int COORD_BITS = 16,
	parameter int MAX_PASSES = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration writes: index 0 x_min, 1 x_max, 2 y_min, 3 y_max.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// Low to high: start_x, start_y, end_x, end_y, zero pad.
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// Low to high: clipped_start_x, clipped_start_y, clipped_end_x,
	// clipped_end_y, zero pad.
	output logic [((4*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
	// Bit 0: visible.
	output logic                               m_axis_tuser
);

	localparam int W = COORD_BITS;
	localparam int TW = ((4*W+7)/8)*8;
	localparam int CW = lsrc_pkg::MAX_COORD_BITS;

	logic signed [W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic en;

	// Rectangle registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= W'(lsrc_pkg::CLIP_MAX_RESET);
			y_min_q <= '0;
			y_max_q <= W'(lsrc_pkg::CLIP_MAX_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lsrc_pkg::REG_X_MIN: x_min_q <= cfg_data;
				lsrc_pkg::REG_X_MAX: x_max_q <= cfg_data;
				lsrc_pkg::REG_Y_MIN: y_min_q <= cfg_data;
				lsrc_pkg::REG_Y_MAX: y_max_q <= cfg_data;
				default: x_min_q <= x_min_q;
			endcase
		end
	end

	// The pipeline moves whenever the output register is free or drains.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic                pv  [0:MAX_PASSES];
	logic signed [W-1:0] px0 [0:MAX_PASSES];
	logic signed [W-1:0] py0 [0:MAX_PASSES];
	logic signed [W-1:0] px1 [0:MAX_PASSES];
	logic signed [W-1:0] py1 [0:MAX_PASSES];
	logic                pf  [0:MAX_PASSES];
	logic [MAX_PASSES-1:0] pass_valid;

	assign pv[0]  = s_axis_tvalid;
	assign px0[0] = s_axis_tdata[W-1:0];
	assign py0[0] = s_axis_tdata[2*W-1:W];
	assign px1[0] = s_axis_tdata[3*W-1:2*W];
	assign py1[0] = s_axis_tdata[4*W-1:3*W];
	assign pf[0]  = 1'b0;

	// Chain of clip passes.
	for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
		lsrc_pass #(.W(W)) u_pass (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.x_min   (x_min_q),
			.x_max   (x_max_q),
			.y_min   (y_min_q),
			.y_max   (y_max_q),
			.valid_i (pv[p]),
			.x0_i    (px0[p]),
			.y0_i    (py0[p]),
			.x1_i    (px1[p]),
			.y1_i    (py1[p]),
			.fault_i (pf[p]),
			.valid_o (pv[p+1]),
			.x0_o    (px0[p+1]),
			.y0_o    (py0[p+1]),
			.x1_o    (px1[p+1]),
			.y1_o    (py1[p+1]),
			.fault_o (pf[p+1])
		);
		assign pass_valid[p] = pv[p+1];
	end

	// Final verdict: visible only when no fault is flagged and both endpoints end up inside.
	lsrc_pkg::outcode_t oc0, oc1;
	logic vis;
	logic [TW-1:0] data_nx;

	always_comb begin
		oc0 = lsrc_pkg::outcode(CW'(px0[MAX_PASSES]), CW'(py0[MAX_PASSES]),
			CW'(x_min_q), CW'(x_max_q), CW'(y_min_q), CW'(y_max_q));
		oc1 = lsrc_pkg::outcode(CW'(px1[MAX_PASSES]), CW'(py1[MAX_PASSES]),
			CW'(x_min_q), CW'(x_max_q), CW'(y_min_q), CW'(y_max_q));
		vis = !pf[MAX_PASSES] && (oc0 == '0) && (oc1 == '0);
		data_nx = '0;
		if (vis) begin
			data_nx[4*W-1:0] = {py1[MAX_PASSES], px1[MAX_PASSES],
				py0[MAX_PASSES], px0[MAX_PASSES]};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= pv[MAX_PASSES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= data_nx;
			m_axis_tuser <= vis;
		end
	end

	// A stalled output freezes every pass.
	`ASSERT_CLK(a_stall_freezes, (m_axis_tvalid && !m_axis_tready) |=> $stable(pass_valid), "pipeline moved during a stall")

	// A hidden segment reports all-zero coordinates.
	`ASSERT_CLK(a_hidden_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "hidden segment carries coordinates")

	// A visible segment has its start point inside the rectangle.
	`ASSERT_CLK(a_visible_inside, (m_axis_tvalid && m_axis_tuser && !$past(cfg_valid)) |-> ($signed(m_axis_tdata[W-1:0]) >= x_min_q && $signed(m_axis_tdata[W-1:0]) <= x_max_q && $signed(m_axis_tdata[2*W-1:W]) >= y_min_q && $signed(m_axis_tdata[2*W-1:W]) <= y_max_q), "visible start point outside rectangle")

endmodule

// ===== design/lsrc_pass.sv =====
// ----------------------------------------------------------------------------
// lsrc_pass
// One clipping pass: pick the outside endpoint, form the edge intersection
// with a multiplier and a one-bit-per-stage divider, and move the endpoint.
// ----------------------------------------------------------------------------
module lsrc_pass #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic signed [W-1:0] x_min,
	input  logic signed [W-1:0] x_max,
	input  logic signed [W-1:0] y_min,
	input  logic signed [W-1:0] y_max,
	input  logic                valid_i,
	input  logic signed [W-1:0] x0_i,
	input  logic signed [W-1:0] y0_i,
	input  logic signed [W-1:0] x1_i,
	input  logic signed [W-1:0] y1_i,
	input  logic                fault_i,
	output logic                valid_o,
	output logic signed [W-1:0] x0_o,
	output logic signed [W-1:0] y0_o,
	output logic signed [W-1:0] x1_o,
	output logic signed [W-1:0] y1_o,
	output logic                fault_o
);

	localparam int CW = lsrc_pkg::MAX_COORD_BITS;

	// State that rides along with a segment through the pass.
	typedef struct packed {
		logic signed [W-1:0] x0;
		logic signed [W-1:0] y0;
		logic signed [W-1:0] x1;
		logic signed [W-1:0] y1;
		logic                fault;
		logic                move;
		logic                vert;
		logic                side;
		logic signed [W-1:0] clip_edge;
		logic signed [W-1:0] base;
		logic                neg;
		logic [W-1:0]        md;
		logic                ovf;
	} carry_t;

	localparam logic signed [W+2:0] SUM_HI = {4'b0000, {(W-1){1'b1}}};
	localparam logic signed [W+2:0] SUM_LO = {4'b1111, {(W-1){1'b0}}};

	function automatic logic [W-1:0] abs_mag(input logic signed [W:0] v);
		logic signed [W:0] t;
		t = v[W] ? -v : v;
		return t[W-1:0];
	endfunction

	// Setup: outcodes, choice of endpoint and edge, operand differences.
	lsrc_pkg::outcode_t c0, c1, csel;
	logic active, vert, is_zero;
	logic signed [W-1:0] edge_sel;
	logic signed [W:0] da, db, dd;
	carry_t carry_nx;
	logic [W-1:0] ma_nx, mb_nx;

	always_comb begin
		c0 = lsrc_pkg::outcode(CW'(x0_i), CW'(y0_i), CW'(x_min), CW'(x_max),
			CW'(y_min), CW'(y_max));
		c1 = lsrc_pkg::outcode(CW'(x1_i), CW'(y1_i), CW'(x_min), CW'(x_max),
			CW'(y_min), CW'(y_max));
		active = !fault_i && ((c0 | c1) != '0) && ((c0 & c1) == '0);
		csel = (c0 != '0) ? c0 : c1;
		vert = csel[lsrc_pkg::OC_TOP] | csel[lsrc_pkg::OC_BOTTOM];
		if (vert) begin
			edge_sel = csel[lsrc_pkg::OC_TOP] ? y_max : y_min;
			da = {x1_i[W-1], x1_i} - {x0_i[W-1], x0_i};
			db = {edge_sel[W-1], edge_sel} - {y0_i[W-1], y0_i};
			dd = {y1_i[W-1], y1_i} - {y0_i[W-1], y0_i};
		end else begin
			edge_sel = csel[lsrc_pkg::OC_RIGHT] ? x_max : x_min;
			da = {y1_i[W-1], y1_i} - {y0_i[W-1], y0_i};
			db = {edge_sel[W-1], edge_sel} - {x0_i[W-1], x0_i};
			dd = {x1_i[W-1], x1_i} - {x0_i[W-1], x0_i};
		end
		is_zero = (dd == '0);
		carry_nx.x0 = x0_i;
		carry_nx.y0 = y0_i;
		carry_nx.x1 = x1_i;
		carry_nx.y1 = y1_i;
		carry_nx.fault = fault_i | (active & is_zero);
		carry_nx.move = active & !is_zero;
		carry_nx.vert = vert;
		carry_nx.side = (c0 != '0);
		carry_nx.clip_edge = edge_sel;
		carry_nx.base = vert ? x0_i : y0_i;
		carry_nx.neg = (da[W] ^ db[W]) ^ dd[W];
		carry_nx.md = abs_mag(dd);
		carry_nx.ovf = 1'b0;
		ma_nx = abs_mag(da);
		mb_nx = abs_mag(db);
	end

	logic valid_s1, valid_s2, valid_s3;
	carry_t carry_s1, carry_s2, carry_s3;
	logic [W-1:0] ma_s1, mb_s1;
	logic [2*W-1:0] prod_s2;
	logic [W-1:0] rem_s3;
	logic [W:0] low_s3;
	carry_t carry_ov;

	// Overflow test: a quotient of 2^(W+1) or more saturates the result.
	always_comb begin
		carry_ov = carry_s2;
		carry_ov.ovf = (W'(prod_s2[2*W-1:W+1]) >= carry_s2.md);
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Setup register, product of magnitudes, then the overflow test.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1 <= carry_nx;
			ma_s1 <= ma_nx;
			mb_s1 <= mb_nx;
			carry_s2 <= carry_s1;
			prod_s2 <= ma_s1 * mb_s1;
			carry_s3 <= carry_ov;
			rem_s3 <= W'(prod_s2[2*W-1:W+1]);
			low_s3 <= prod_s2[W:0];
		end
	end

	// Divider: one quotient bit per stage over the low W+1 dividend bits.
	logic         valid_sd [0:W];
	carry_t       carry_sd [0:W];
	logic [W-1:0] rem_sd   [0:W];
	logic [W:0]   low_sd   [0:W];
	logic [W:0]   q_sd     [0:W];

	for (genvar k = 0; k <= W; k++) begin : g_div
		logic         v_in;
		carry_t       c_in;
		logic [W-1:0] r_in;
		logic [W:0]   l_in;
		logic [W:0]   q_in;
		logic [W:0]   trial;
		logic         ge;

		if (k == 0) begin : g_first
			assign v_in = valid_s3;
			assign c_in = carry_s3;
			assign r_in = rem_s3;
			assign l_in = low_s3;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = valid_sd[k-1];
			assign c_in = carry_sd[k-1];
			assign r_in = rem_sd[k-1];
			assign l_in = low_sd[k-1];
			assign q_in = q_sd[k-1];
		end

		assign trial = {r_in, l_in[W]};
		assign ge = (trial >= {1'b0, c_in.md});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sd[k] <= 1'b0;
			end else if (en) begin
				valid_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				carry_sd[k] <= c_in;
				rem_sd[k] <= ge ? W'(trial - {1'b0, c_in.md}) : W'(trial);
				low_sd[k] <= {l_in[W-1:0], 1'b0};
				q_sd[k] <= {q_in[W-1:0], ge};
			end
		end
	end

	// Finish: signed quotient plus base, saturated, written to the endpoint.
	carry_t cf;
	logic [W+1:0] qmag;
	logic signed [W+2:0] qsig, sum;
	logic signed [W-1:0] res;
	carry_t carry_fin;

	always_comb begin
		cf = carry_sd[W];
		qmag = cf.ovf ? ((W+2)'(1) << (W+1)) : {1'b0, q_sd[W]};
		qsig = cf.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		sum = {{3{cf.base[W-1]}}, cf.base} + qsig;
		if (sum > SUM_HI) begin
			res = SUM_HI[W-1:0];
		end else if (sum < SUM_LO) begin
			res = SUM_LO[W-1:0];
		end else begin
			res = sum[W-1:0];
		end
		carry_fin = cf;
		if (cf.move) begin
			if (cf.side) begin
				carry_fin.x0 = cf.vert ? res : cf.clip_edge;
				carry_fin.y0 = cf.vert ? cf.clip_edge : res;
			end else begin
				carry_fin.x1 = cf.vert ? res : cf.clip_edge;
				carry_fin.y1 = cf.vert ? cf.clip_edge : res;
			end
		end
	end

	logic valid_s4;
	carry_t carry_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_sd[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s4 <= carry_fin;
		end
	end

	assign valid_o = valid_s4;
	assign x0_o = carry_s4.x0;
	assign y0_o = carry_s4.y0;
	assign x1_o = carry_s4.x1;
	assign y1_o = carry_s4.y1;
	assign fault_o = carry_s4.fault;

endmodule

// ===== dv/line_segment_rect_clip_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_rect_clip_top_tb
// Drives segments through the clipper under several clip rectangles, including
// the extremes and an inverted rectangle. Each segment is clipped by a local
// Cohen-Sutherland model, and every returned transaction is compared in order.
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [15:0] sx;
	logic signed [15:0] sy;
	logic signed [15:0] ex;
	logic signed [15:0] ey;
	logic               vis;
} clip_seg_t;

class clip_scoreboard;
	longint x_min, x_max, y_min, y_max;
	clip_seg_t expected_clips[$];
	int mismatches;

	function new();
		x_min = 0;
		x_max = 32767;
		y_min = 0;
		y_max = 32767;
		mismatches = 0;
	endfunction

	function void set_edge(lsrc_pkg::clip_reg_t idx, logic signed [15:0] v);
		case (idx)
			lsrc_pkg::REG_X_MIN: x_min = v;
			lsrc_pkg::REG_X_MAX: x_max = v;
			lsrc_pkg::REG_Y_MIN: y_min = v;
			default: y_max = v;
		endcase
	endfunction

	function logic [3:0] region(longint x, longint y);
		logic [3:0] c;
		c = '0;
		if (x < x_min) c[lsrc_pkg::OC_LEFT] = 1'b1;
		else if (x > x_max) c[lsrc_pkg::OC_RIGHT] = 1'b1;
		if (y < y_min) c[lsrc_pkg::OC_BOTTOM] = 1'b1;
		else if (y > y_max) c[lsrc_pkg::OC_TOP] = 1'b1;
		return c;
	endfunction

	function longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Cohen-Sutherland with a pass limit; division truncates toward zero.
	function clip_seg_t clip_segment(clip_seg_t s);
		longint x0, y0, x1, y1, nx, ny, edge_v, d;
		logic [3:0] c0, c1, c;
		bit fault;
		int pass;
		clip_seg_t r;
		x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
		c0 = region(x0, y0);
		c1 = region(x1, y1);
		fault = 0;
		pass = 0;
		while (!(c0 == 0 && c1 == 0) && (c0 & c1) == 0 && pass < 4) begin
			c = (c0 != 0) ? c0 : c1;
			if (c[lsrc_pkg::OC_TOP] || c[lsrc_pkg::OC_BOTTOM]) begin
				edge_v = c[lsrc_pkg::OC_TOP] ? y_max : y_min;
				d = y1 - y0;
				if (d == 0) begin
					fault = 1;
					break;
				end
				nx = clamp16(x0 + ((x1 - x0) * (edge_v - y0)) / d);
				ny = edge_v;
			end else begin
				edge_v = c[lsrc_pkg::OC_RIGHT] ? x_max : x_min;
				d = x1 - x0;
				if (d == 0) begin
					fault = 1;
					break;
				end
				ny = clamp16(y0 + ((y1 - y0) * (edge_v - x0)) / d);
				nx = edge_v;
			end
			if (c0 != 0) begin
				x0 = nx; y0 = ny; c0 = region(x0, y0);
			end else begin
				x1 = nx; y1 = ny; c1 = region(x1, y1);
			end
			pass++;
		end
		r.vis = !fault && c0 == 0 && c1 == 0;
		if (!r.vis) begin
			x0 = 0; y0 = 0; x1 = 0; y1 = 0;
		end
		r.sx = 16'(x0); r.sy = 16'(y0); r.ex = 16'(x1); r.ey = 16'(y1);
		return r;
	endfunction

	function void note_segment(clip_seg_t s);
		expected_clips.push_back(clip_segment(s));
	endfunction

	function void check_clip(logic [63:0] data, logic vis);
		clip_seg_t e;
		if (expected_clips.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result transaction: data=%h visible=%b", data, vis);
			return;
		end
		e = expected_clips.pop_front();
		if (data !== {e.ey, e.ex, e.sy, e.sx} || vis !== e.vis) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch: expected sx=%0d sy=%0d ex=%0d ey=%0d vis=%b, got sx=%0d sy=%0d ex=%0d ey=%0d vis=%b",
					e.sx, e.sy, e.ex, e.ey, e.vis,
					$signed(data[15:0]), $signed(data[31:16]),
					$signed(data[47:32]), $signed(data[63:48]), vis);
		end
	endfunction
endclass

module line_segment_rect_clip_top_tb;
	localparam int LATENCY = 4 * (16 + 5) + 1;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;

	clip_scoreboard sb = new();
	bit calm;
	bit long_hold;
	longint rx_lo, rx_hi, ry_lo, ry_hi;

	line_segment_rect_clip_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Overall time limit.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Compare every accepted result transaction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_clip(m_axis_tdata, m_axis_tuser);
	end

	// Receiver back-pressure: random stalls, one long hold-off on request.
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(1, 7);
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end
		end
	end

	// Write one edge register once the pipeline has drained.
	task automatic write_edge(lsrc_pkg::clip_reg_t idx, logic signed [15:0] v);
		s_axis_tvalid <= 1'b0;
		wait (sb.expected_clips.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_edge(idx, v);
	endtask

	task automatic set_rect(longint xl, longint xh, longint yl, longint yh);
		write_edge(lsrc_pkg::REG_X_MIN, 16'(xl));
		write_edge(lsrc_pkg::REG_X_MAX, 16'(xh));
		write_edge(lsrc_pkg::REG_Y_MIN, 16'(yl));
		write_edge(lsrc_pkg::REG_Y_MAX, 16'(yh));
		rx_lo = xl; rx_hi = xh; ry_lo = yl; ry_hi = yh;
	endtask

	// Offer one segment and hold it until accepted, then maybe idle.
	task automatic send_segment(longint sx, longint sy, longint ex, longint ey);
		clip_seg_t s;
		int gap;
		s.sx = 16'(sx); s.sy = 16'(sy); s.ex = 16'(ex); s.ey = 16'(ey); s.vis = 0;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {s.ey, s.ex, s.sy, s.sx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_segment(s);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic longint near_coord(longint lo, longint hi);
		longint a, b, v;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		v = a - 300 + longint'($urandom_range(0, 32'(b - a + 600)));
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	task automatic random_segments(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 6)
				send_segment(near_coord(rx_lo, rx_hi), near_coord(ry_lo, ry_hi),
					near_coord(rx_lo, rx_hi), near_coord(ry_lo, ry_hi));
			else
				send_segment($signed(16'($urandom)), $signed(16'($urandom)),
					$signed(16'($urandom)), $signed(16'($urandom)));
		end
	endtask

	initial begin
		longint a, b;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lsrc_pkg::REG_X_MIN;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		calm = 0;
		long_hold = 0;
		rx_lo = 0; rx_hi = 32767; ry_lo = 0; ry_hi = 32767;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rectangle: inside, edge crossings, extreme corners, rejects.
		send_segment(10, 20, 300, 400);
		send_segment(-500, 100, 500, 200);
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(32767, 32767, -32768, -32768);
		send_segment(-100, -100, -5, -7);
		send_segment(100, -400, 100, 400);
		send_segment(0, 0, 32767, 32767);

		// Ordinary rectangle: two-sided, corner cut, reject, axis-parallel lines.
		set_rect(-1000, 1000, -800, 800);
		send_segment(-2000, 0, 2000, 0);
		send_segment(0, -2000, 0, 2000);
		send_segment(-1500, 700, -700, 1500);
		send_segment(1200, -900, 1500, 900);
		send_segment(-3000, -2500, 3000, 2600);
		send_segment(-1100, 900, 1100, 900);
		send_segment(500, 500, 500, 500);

		// Inverted rectangle: zero divisors and saturated intersections.
		set_rect(100, -100, 100, -100);
		send_segment(0, -30000, 0, 30000);
		send_segment(-30000, 0, 30000, 0);
		send_segment(-32768, 32767, 32767, -32768);
		send_segment(50, 60, -70, 80);

		// Degenerate point rectangle.
		set_rect(0, 0, 0, 0);
		send_segment(-16, -16, 16, 16);
		send_segment(-16, 0, 16, 0);
		send_segment(0, 0, 0, 0);

		// Random phases over several rectangles.
		set_rect(-1000, 1000, -800, 800);
		random_segments(150);
		long_hold = 1;
		random_segments(200);
		set_rect(-32768, 32767, -32768, 32767);
		random_segments(250);
		set_rect(300, -300, 200, -200);
		random_segments(250);
		set_rect(0, 0, 0, 0);
		random_segments(200);
		a = $signed(16'($urandom));
		b = $signed(16'($urandom));
		set_rect(a, b, b, a);
		random_segments(200);
		set_rect(-32768, -32768, 32767, 32767);
		random_segments(150);
		set_rect(-4000, 2000, -1000, 5000);
		calm = 1;
		random_segments(480);
		s_axis_tvalid <= 1'b0;

		wait (sb.expected_clips.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_clips.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ===== line_segment_rect_clip_top.f =====
+incdir+design
design/lsrc_pkg.sv
design/lsrc_pass.sv
design/line_segment_rect_clip_top.sv
dv/line_segment_rect_clip_top_tb.sv
